// ===== design/abkf_pkg.sv =====
// ----------------------------------------------------------------------------
// abkf_pkg
// Shared types and constants of the angle and gyro bias Kalman filter.
// ----------------------------------------------------------------------------
package abkf_pkg;

  // Fixed-point format: Q4.28 for covariance, noises, gains and time step.
  localparam int QF = 28;

  // Full product of two 32 bit signed operands, and its rounded Q28 form.
  localparam int PROD_W = 64;
  localparam int RND_W  = PROD_W + 1 - QF;

  // Innovation variance is kept exact: noise plus one rounded product.
  localparam int E_W = RND_W + 1;

  // Last multiply phase: operands at phase 0, rounded product usable at this phase.
  localparam logic [1:0] MUL_PH_LAST = 2'd2;

  // Configuration port.
  localparam int CFG_AW = 5;
  localparam int CFG_DW = 32;

  localparam logic [2:0] REG_TIME_STEP     = 3'd0;
  localparam logic [2:0] REG_ANGLE_NOISE   = 3'd1;
  localparam logic [2:0] REG_BIAS_NOISE    = 3'd2;
  localparam logic [2:0] REG_MEASURE_NOISE = 3'd3;
  localparam logic [2:0] REG_MEASURE_GAIN  = 3'd4;

  localparam logic [30:0]        TIME_STEP_RST     = 31'd1342177;
  localparam logic [30:0]        ANGLE_NOISE_RST   = 31'd268435;
  localparam logic [30:0]        BIAS_NOISE_RST    = 31'd805306;
  localparam logic [30:0]        MEASURE_NOISE_RST = 31'd134217728;
  localparam logic signed [31:0] MEASURE_GAIN_RST  = 32'sd268435456;

  // 1.0 in Q4.28, the diagonal of the covariance after reset.
  localparam logic signed [31:0] P_ONE = 32'sh1000_0000;

  localparam logic signed [31:0] MAX32 = 32'sh7fff_ffff;
  localparam logic signed [31:0] MIN32 = 32'sh8000_0000;

  typedef struct packed {
    logic [30:0]        time_step;
    logic [30:0]        angle_noise;
    logic [30:0]        bias_noise;
    logic [30:0]        measure_noise;
    logic signed [31:0] measure_gain;
  } cfg_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_DIFF,
    ST_PRED,
    ST_D0A,
    ST_D0B,
    ST_P00,
    ST_D1,
    ST_P01,
    ST_P10,
    ST_P11,
    ST_ERR,
    ST_PCT0,
    ST_PCT1,
    ST_E,
    ST_T1,
    ST_DIV0,
    ST_K0,
    ST_DIV1,
    ST_K1,
    ST_C00,
    ST_C01,
    ST_C10,
    ST_C11,
    ST_ANG,
    ST_BIAS,
    ST_RATE
  } state_t;

endpackage

// ===== design/abkf_if.sv =====
// ----------------------------------------------------------------------------
// abkf_if
// Valid/ready channels for samples in and filter results out.
// ----------------------------------------------------------------------------
interface abkf_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] accel_angle;
  logic signed [31:0] gyro_rate;

  modport source (output valid, output accel_angle, output gyro_rate, input ready);
  modport sink   (input valid, input accel_angle, input gyro_rate, output ready);
endinterface

interface abkf_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] filtered_angle;
  logic signed [31:0] corrected_rate;
  logic signed [31:0] bias_estimate;

  modport source (output valid, output filtered_angle, output corrected_rate,
                  output bias_estimate, input ready);
  modport sink   (input valid, input filtered_angle, input corrected_rate,
                  input bias_estimate, output ready);
endinterface

// ===== design/angle_bias_kalman_filter.sv =====
// ----------------------------------------------------------------------------
// angle_bias_kalman_filter
// Two-state Kalman filter fusing an accelerometer angle with a gyro rate.
//
// Each accepted sample (accel_angle, gyro_rate, both Q16.16) produces one
// result: the filtered angle, the gyro rate minus the new bias estimate, and
// the bias estimate, all Q16.16 and saturated to 32 bits. The filter works on
// one sample at a time. A sequencer drives a single shared 32x32 multiplier
// (product and rounding both registered) and a shared adder with
// saturation, and a restoring divider forms each of the two gains at one
// quotient bit per cycle. When the innovation variance is not positive, the
// divisions are skipped. The input is ready again as soon as the result is
// loaded into the output register, so the next sample can be taken while the
// result waits for its transfer. Configuration registers (APB, byte address
// 4*i: time_step, angle_noise, bias_noise, measure_noise, measure_gain) must
// be written only while no sample is in flight; the block itself does not
// enforce this. Reset sets the covariance to identity and the angle and bias
// to zero. DATA_WIDTH sets the width of the stored angle and bias, which
// saturate to that width.
// ----------------------------------------------------------------------------
module angle_bias_kalman_filter #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  abkf_in_if.sink                     in_ch,
  abkf_out_if.source                  out_ch,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [abkf_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [abkf_pkg::CFG_DW-1:0] cfg_pwdata,
  output logic [abkf_pkg::CFG_DW-1:0] cfg_prdata,
  output logic                        cfg_pready
);
  import abkf_pkg::*;

  // The shared adder is wide enough for the stored angle plus a rounded product.
  localparam int ACC_W = ((DATA_WIDTH > RND_W) ? DATA_WIDTH : RND_W) + 2;
  localparam logic signed [DATA_WIDTH-1:0] MAX_DW = {1'b0, {(DATA_WIDTH - 1){1'b1}}};
  localparam logic signed [DATA_WIDTH-1:0] MIN_DW = {1'b1, {(DATA_WIDTH - 1){1'b0}}};

  function automatic logic signed [31:0] sat32f(input logic signed [ACC_W-1:0] v);
    logic fits;
    fits = (&v[ACC_W-1:31]) || !(|v[ACC_W-1:31]);
    if (fits) begin
      return v[31:0];
    end else if (v[ACC_W-1]) begin
      return MIN32;
    end else begin
      return MAX32;
    end
  endfunction

  function automatic logic signed [DATA_WIDTH-1:0] satdwf(input logic signed [ACC_W-1:0] v);
    logic fits;
    fits = (&v[ACC_W-1:DATA_WIDTH-1]) || !(|v[ACC_W-1:DATA_WIDTH-1]);
    if (fits) begin
      return v[DATA_WIDTH-1:0];
    end else if (v[ACC_W-1]) begin
      return MIN_DW;
    end else begin
      return MAX_DW;
    end
  endfunction

  cfg_t cfg;

  // Sequencer state.
  state_t     state_r, state_nxt;
  logic [1:0] ph_r, ph_nxt;

  // Filter state carried from sample to sample.
  logic signed [DATA_WIDTH-1:0] angle_r, angle_nxt;
  logic signed [DATA_WIDTH-1:0] bias_r, bias_nxt;
  logic signed [31:0]           p00_r, p00_nxt, p01_r, p01_nxt;
  logic signed [31:0]           p10_r, p10_nxt, p11_r, p11_nxt;

  // Working registers of the sample in flight.
  logic signed [31:0]           accel_r, accel_nxt, gyro_r, gyro_nxt;
  logic signed [DATA_WIDTH-1:0] pred_r, pred_nxt;
  logic signed [31:0]           opnd_r, opnd_nxt, err_r, err_nxt;
  logic signed [31:0]           pct0_r, pct0_nxt, pct1_r, pct1_nxt, t1_r, t1_nxt;
  logic signed [31:0]           k0_r, k0_nxt, k1_r, k1_nxt;
  logic signed [ACC_W-1:0]      acc_r, acc_nxt;
  logic signed [E_W-1:0]        e_r, e_nxt;

  // Output register.
  logic               out_valid_r, out_valid_nxt;
  logic signed [31:0] filt_r, filt_nxt, rate_r, rate_nxt, bias_out_r, bias_out_nxt;

  // Shared arithmetic.
  logic signed [31:0]       mul_a, mul_b;
  logic signed [RND_W-1:0]  mul_rnd;
  logic                     mul_op, mul_last;
  logic signed [ACC_W-1:0]  alu_a, alu_b, alu_sum;
  logic                     alu_sub;
  logic signed [31:0]       alu_s32;
  logic signed [DATA_WIDTH-1:0] alu_sdw;
  logic signed [31:0]       dt, c_gain;

  logic                     div_start, div_done;
  logic signed [31:0]       div_num, div_quo;
  logic                     out_free;

  abkf_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  abkf_mul u_mul (
    .clk   (clk),
    .mul_a (mul_a),
    .mul_b (mul_b),
    .rnd   (mul_rnd)
  );

  abkf_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (e_r),
    .done  (div_done),
    .quo   (div_quo)
  );

  assign dt       = signed'({1'b0, cfg.time_step});
  assign c_gain   = cfg.measure_gain;
  assign mul_last = (ph_r == MUL_PH_LAST);
  assign div_num  = (state_r == ST_DIV1) ? pct1_r : pct0_r;
  assign out_free = !out_valid_r || out_ch.ready;

  // Operand selection for the multiplier and the adder. A multiply state holds
  // its operands through all its phases; its rounded product is used in the last.
  always_comb begin
    mul_a   = '0;
    mul_b   = '0;
    mul_op  = 1'b0;
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b0;
    unique case (state_r)
      ST_DIFF, ST_RATE: begin
        alu_a   = ACC_W'(gyro_r);
        alu_b   = ACC_W'(bias_r);
        alu_sub = 1'b1;
      end
      ST_PRED: begin
        mul_op = 1'b1; mul_a = opnd_r; mul_b = dt;
        alu_a  = ACC_W'(angle_r);
        alu_b  = ACC_W'(mul_rnd);
      end
      ST_D0A: begin
        alu_a   = ACC_W'(cfg.angle_noise);
        alu_b   = ACC_W'(p01_r);
        alu_sub = 1'b1;
      end
      ST_D0B: begin
        alu_a   = acc_r;
        alu_b   = ACC_W'(p10_r);
        alu_sub = 1'b1;
      end
      ST_P00: begin
        mul_op = 1'b1; mul_a = opnd_r; mul_b = dt;
        alu_a  = ACC_W'(p00_r);
        alu_b  = ACC_W'(mul_rnd);
      end
      ST_D1: begin
        alu_b   = ACC_W'(p11_r);
        alu_sub = 1'b1;
      end
      ST_P01: begin
        mul_op = 1'b1; mul_a = opnd_r; mul_b = dt;
        alu_a  = ACC_W'(p01_r);
        alu_b  = ACC_W'(mul_rnd);
      end
      ST_P10: begin
        mul_op = 1'b1; mul_a = opnd_r; mul_b = dt;
        alu_a  = ACC_W'(p10_r);
        alu_b  = ACC_W'(mul_rnd);
      end
      ST_P11: begin
        mul_op = 1'b1; mul_a = signed'({1'b0, cfg.bias_noise}); mul_b = dt;
        alu_a  = ACC_W'(p11_r);
        alu_b  = ACC_W'(mul_rnd);
      end
      ST_ERR: begin
        alu_a   = ACC_W'(accel_r);
        alu_b   = ACC_W'(pred_r);
        alu_sub = 1'b1;
      end
      ST_PCT0: begin
        mul_op = 1'b1; mul_a = c_gain; mul_b = p00_r;
        alu_b  = ACC_W'(mul_rnd);
      end
      ST_PCT1: begin
        mul_op = 1'b1; mul_a = c_gain; mul_b = p10_r;
        alu_b  = ACC_W'(mul_rnd);
      end
      ST_E: begin
        mul_op = 1'b1; mul_a = c_gain; mul_b = pct0_r;
        alu_a  = ACC_W'(cfg.measure_noise);
        alu_b  = ACC_W'(mul_rnd);
      end
      ST_T1: begin
        mul_op = 1'b1; mul_a = c_gain; mul_b = p01_r;
        alu_b  = ACC_W'(mul_rnd);
      end
      ST_C00: begin
        mul_op = 1'b1; mul_a = k0_r; mul_b = pct0_r;
        alu_a  = ACC_W'(p00_r); alu_b = ACC_W'(mul_rnd); alu_sub = 1'b1;
      end
      ST_C01: begin
        mul_op = 1'b1; mul_a = k0_r; mul_b = t1_r;
        alu_a  = ACC_W'(p01_r); alu_b = ACC_W'(mul_rnd); alu_sub = 1'b1;
      end
      ST_C10: begin
        mul_op = 1'b1; mul_a = k1_r; mul_b = pct0_r;
        alu_a  = ACC_W'(p10_r); alu_b = ACC_W'(mul_rnd); alu_sub = 1'b1;
      end
      ST_C11: begin
        mul_op = 1'b1; mul_a = k1_r; mul_b = t1_r;
        alu_a  = ACC_W'(p11_r); alu_b = ACC_W'(mul_rnd); alu_sub = 1'b1;
      end
      ST_ANG: begin
        mul_op = 1'b1; mul_a = k0_r; mul_b = err_r;
        alu_a  = ACC_W'(pred_r);
        alu_b  = ACC_W'(mul_rnd);
      end
      ST_BIAS: begin
        mul_op = 1'b1; mul_a = k1_r; mul_b = err_r;
        alu_a  = ACC_W'(bias_r);
        alu_b  = ACC_W'(mul_rnd);
      end
      default: begin
        mul_op = 1'b0;
      end
    endcase
  end

  assign alu_sum = alu_sub ? (alu_a - alu_b) : (alu_a + alu_b);
  assign alu_s32 = sat32f(alu_sum);
  assign alu_sdw = satdwf(alu_sum);

  // Sequencer: next state and register updates.
  always_comb begin
    state_nxt     = state_r;
    ph_nxt        = ph_r;
    angle_nxt     = angle_r;
    bias_nxt      = bias_r;
    p00_nxt       = p00_r;
    p01_nxt       = p01_r;
    p10_nxt       = p10_r;
    p11_nxt       = p11_r;
    accel_nxt     = accel_r;
    gyro_nxt      = gyro_r;
    pred_nxt      = pred_r;
    opnd_nxt      = opnd_r;
    err_nxt       = err_r;
    pct0_nxt      = pct0_r;
    pct1_nxt      = pct1_r;
    t1_nxt        = t1_r;
    k0_nxt        = k0_r;
    k1_nxt        = k1_r;
    acc_nxt       = acc_r;
    e_nxt         = e_r;
    filt_nxt      = filt_r;
    rate_nxt      = rate_r;
    bias_out_nxt  = bias_out_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    div_start     = 1'b0;

    if (mul_op) begin
      ph_nxt = mul_last ? '0 : ph_r + 2'd1;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          accel_nxt = in_ch.accel_angle;
          gyro_nxt  = in_ch.gyro_rate;
          state_nxt = ST_DIFF;
        end
      end
      // Prediction of the angle from the bias-corrected rate.
      ST_DIFF: begin
        opnd_nxt  = alu_s32;
        state_nxt = ST_PRED;
      end
      ST_PRED: begin
        if (mul_last) begin
          pred_nxt  = alu_sdw;
          state_nxt = ST_D0A;
        end
      end
      // Covariance propagation; the derivative terms use the old covariance.
      ST_D0A: begin
        acc_nxt   = alu_sum;
        state_nxt = ST_D0B;
      end
      ST_D0B: begin
        opnd_nxt  = alu_s32;
        state_nxt = ST_P00;
      end
      ST_P00: begin
        if (mul_last) begin
          p00_nxt   = alu_s32;
          state_nxt = ST_D1;
        end
      end
      ST_D1: begin
        opnd_nxt  = alu_s32;
        state_nxt = ST_P01;
      end
      ST_P01: begin
        if (mul_last) begin
          p01_nxt   = alu_s32;
          state_nxt = ST_P10;
        end
      end
      ST_P10: begin
        if (mul_last) begin
          p10_nxt   = alu_s32;
          state_nxt = ST_P11;
        end
      end
      ST_P11: begin
        if (mul_last) begin
          p11_nxt   = alu_s32;
          state_nxt = ST_ERR;
        end
      end
      // Innovation, its variance, and the terms of the gains.
      ST_ERR: begin
        err_nxt   = alu_s32;
        state_nxt = ST_PCT0;
      end
      ST_PCT0: begin
        if (mul_last) begin
          pct0_nxt  = alu_s32;
          state_nxt = ST_PCT1;
        end
      end
      ST_PCT1: begin
        if (mul_last) begin
          pct1_nxt  = alu_s32;
          state_nxt = ST_E;
        end
      end
      ST_E: begin
        if (mul_last) begin
          e_nxt     = alu_sum[E_W-1:0];
          state_nxt = ST_T1;
        end
      end
      ST_T1: begin
        if (mul_last) begin
          t1_nxt    = alu_s32;
          state_nxt = ST_DIV0;
        end
      end
      // Gains; both are zero when the innovation variance is not positive.
      ST_DIV0: begin
        if (e_r > 0) begin
          div_start = 1'b1;
          state_nxt = ST_K0;
        end else begin
          k0_nxt    = '0;
          k1_nxt    = '0;
          state_nxt = ST_C00;
        end
      end
      ST_K0: begin
        if (div_done) begin
          k0_nxt    = div_quo;
          state_nxt = ST_DIV1;
        end
      end
      ST_DIV1: begin
        div_start = 1'b1;
        state_nxt = ST_K1;
      end
      ST_K1: begin
        if (div_done) begin
          k1_nxt    = div_quo;
          state_nxt = ST_C00;
        end
      end
      // Correction of covariance, angle and bias.
      ST_C00: begin
        if (mul_last) begin
          p00_nxt   = alu_s32;
          state_nxt = ST_C01;
        end
      end
      ST_C01: begin
        if (mul_last) begin
          p01_nxt   = alu_s32;
          state_nxt = ST_C10;
        end
      end
      ST_C10: begin
        if (mul_last) begin
          p10_nxt   = alu_s32;
          state_nxt = ST_C11;
        end
      end
      ST_C11: begin
        if (mul_last) begin
          p11_nxt   = alu_s32;
          state_nxt = ST_ANG;
        end
      end
      ST_ANG: begin
        if (mul_last) begin
          angle_nxt = alu_sdw;
          state_nxt = ST_BIAS;
        end
      end
      ST_BIAS: begin
        if (mul_last) begin
          bias_nxt  = alu_sdw;
          state_nxt = ST_RATE;
        end
      end
      // Load the result once the output register is free.
      ST_RATE: begin
        if (out_free) begin
          rate_nxt      = alu_s32;
          filt_nxt      = sat32f(ACC_W'(angle_r));
          bias_out_nxt  = sat32f(ACC_W'(bias_r));
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ph_r        <= '0;
      out_valid_r <= 1'b0;
      angle_r     <= '0;
      bias_r      <= '0;
      p00_r       <= P_ONE;
      p01_r       <= '0;
      p10_r       <= '0;
      p11_r       <= P_ONE;
    end else begin
      state_r     <= state_nxt;
      ph_r        <= ph_nxt;
      out_valid_r <= out_valid_nxt;
      angle_r     <= angle_nxt;
      bias_r      <= bias_nxt;
      p00_r       <= p00_nxt;
      p01_r       <= p01_nxt;
      p10_r       <= p10_nxt;
      p11_r       <= p11_nxt;
    end
  end

  always_ff @(posedge clk) begin
    accel_r    <= accel_nxt;
    gyro_r     <= gyro_nxt;
    pred_r     <= pred_nxt;
    opnd_r     <= opnd_nxt;
    err_r      <= err_nxt;
    pct0_r     <= pct0_nxt;
    pct1_r     <= pct1_nxt;
    t1_r       <= t1_nxt;
    k0_r       <= k0_nxt;
    k1_r       <= k1_nxt;
    acc_r      <= acc_nxt;
    e_r        <= e_nxt;
    filt_r     <= filt_nxt;
    rate_r     <= rate_nxt;
    bias_out_r <= bias_out_nxt;
  end

  assign in_ch.ready           = (state_r == ST_IDLE);
  assign out_ch.valid          = out_valid_r;
  assign out_ch.filtered_angle = filt_r;
  assign out_ch.corrected_rate = rate_r;
  assign out_ch.bias_estimate  = bias_out_r;

endmodule

// ===== design/abkf_cfg.sv =====
// ----------------------------------------------------------------------------
// abkf_cfg
// APB register bank holding the time step, the noises and the measure gain.
// ----------------------------------------------------------------------------
module abkf_cfg (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [abkf_pkg::CFG_AW-1:0] paddr,
  input  logic [abkf_pkg::CFG_DW-1:0] pwdata,
  output logic [abkf_pkg::CFG_DW-1:0] prdata,
  output logic                        pready,
  output abkf_pkg::cfg_t              cfg
);
  import abkf_pkg::*;

  cfg_t       cfg_r;
  cfg_t       cfg_nxt;
  logic [2:0] reg_idx;
  logic       wr_en;

  assign reg_idx = paddr[4:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;
  assign cfg     = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (reg_idx)
        REG_TIME_STEP:     cfg_nxt.time_step     = pwdata[30:0];
        REG_ANGLE_NOISE:   cfg_nxt.angle_noise   = pwdata[30:0];
        REG_BIAS_NOISE:    cfg_nxt.bias_noise    = pwdata[30:0];
        REG_MEASURE_NOISE: cfg_nxt.measure_noise = pwdata[30:0];
        REG_MEASURE_GAIN:  cfg_nxt.measure_gain  = signed'(pwdata);
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_TIME_STEP:     prdata = {1'b0, cfg_r.time_step};
      REG_ANGLE_NOISE:   prdata = {1'b0, cfg_r.angle_noise};
      REG_BIAS_NOISE:    prdata = {1'b0, cfg_r.bias_noise};
      REG_MEASURE_NOISE: prdata = {1'b0, cfg_r.measure_noise};
      REG_MEASURE_GAIN:  prdata = cfg_r.measure_gain;
      default:           prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.time_step     <= TIME_STEP_RST;
      cfg_r.angle_noise   <= ANGLE_NOISE_RST;
      cfg_r.bias_noise    <= BIAS_NOISE_RST;
      cfg_r.measure_noise <= MEASURE_NOISE_RST;
      cfg_r.measure_gain  <= MEASURE_GAIN_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// ===== design/abkf_mul.sv =====
// ----------------------------------------------------------------------------
// abkf_mul
// Shared 32x32 signed multiplier with a registered Q28 rounding stage.
// ----------------------------------------------------------------------------
module abkf_mul (
  input  logic                              clk,
  input  logic signed [31:0]                mul_a,
  input  logic signed [31:0]                mul_b,
  output logic signed [abkf_pkg::RND_W-1:0] rnd
);
  import abkf_pkg::*;

  localparam logic [PROD_W:0] HALF_LSB = (PROD_W + 1)'(1) << (QF - 1);

  logic signed [PROD_W-1:0] prod_r;
  logic signed [RND_W-1:0]  rnd_r;
  logic [PROD_W:0]          half_sum;

  // Round to nearest with ties upward: add half an LSB, then floor.
  assign half_sum = {prod_r[PROD_W-1], prod_r} + HALF_LSB;
  assign rnd      = rnd_r;

  always_ff @(posedge clk) begin
    prod_r <= PROD_W'(mul_a) * PROD_W'(mul_b);
    rnd_r  <= signed'(half_sum[PROD_W:QF]);
  end

endmodule

// ===== design/abkf_div.sv =====
// ----------------------------------------------------------------------------
// abkf_div
// Restoring divider for the gains: (num << 28) / den, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module abkf_div (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic signed [31:0]              num,
  input  logic signed [abkf_pkg::E_W-1:0] den,
  output logic                            done,
  output logic signed [31:0]              quo
);
  import abkf_pkg::*;

  localparam int MAG_W = 32;
  localparam int NUM_W = MAG_W + QF;
  localparam int DEN_W = E_W - 1;
  localparam int DSH_W = DEN_W + MAG_W - 1;
  localparam int CNT_W = $clog2(MAG_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MAG_W - 1);
  localparam logic [MAG_W-1:0] NEG_LIMIT = {1'b1, {(MAG_W - 1){1'b0}}};

  logic             busy_r, done_r, neg_r, ovf_r;
  logic [CNT_W-1:0] cnt_r;
  logic [NUM_W-1:0] rem_r;
  logic [DSH_W-1:0] dsh_r;
  logic [MAG_W-1:0] q_r;
  logic [MAG_W-1:0] mag;
  logic             ge;

  assign mag = num[MAG_W-1] ? (~num + 1'b1) : num;
  assign ge  = (DSH_W'(rem_r) >= dsh_r);

  // The quotient only fits in 32 bits when (num << 28) < den << 32,
  // which reduces to a compare of the top bits of the magnitude.
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= {mag, QF'(0)};
      dsh_r <= DSH_W'(den[DEN_W-1:0]) << (MAG_W - 1);
      q_r   <= '0;
      neg_r <= num[MAG_W-1];
      ovf_r <= (DEN_W'(mag[MAG_W-1:MAG_W-QF]) >= den[DEN_W-1:0]);
    end else if (busy_r) begin
      if (ge) begin
        rem_r <= rem_r - dsh_r[NUM_W-1:0];
      end
      dsh_r <= dsh_r >> 1;
      q_r   <= {q_r[MAG_W-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == CNT_LAST);
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_LAST) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_comb begin
    if (neg_r) begin
      quo = (ovf_r || (q_r > NEG_LIMIT)) ? MIN32 : signed'(~q_r + 1'b1);
    end else begin
      quo = (ovf_r || q_r[MAG_W-1]) ? MAX32 : signed'(q_r);
    end
  end

  assign done = done_r;

endmodule

// ===== design/abkf_chk.sv =====
// ----------------------------------------------------------------------------
// abkf_chk
// Port-level checks of the filter's channel behavior, bound to the top level.
// ----------------------------------------------------------------------------
module abkf_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] filtered_angle,
  input logic [31:0] corrected_rate,
  input logic [31:0] bias_estimate
);

  // A stalled result keeps its value until its transfer.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(filtered_angle) &&
      $stable(corrected_rate) && $stable(bias_estimate))
    else $error("result changed or dropped while stalled");

  // Only one sample is in flight: the input closes right after a transfer.
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input still ready after taking a sample");

  // A new result appears together with the input opening again.
  a_result_frees_input: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> in_ready)
    else $error("result shown while input still closed");

  // A result never follows its sample in the very next cycle.
  a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !$past(in_valid && in_ready))
    else $error("result appeared one cycle after a sample");

endmodule

bind angle_bias_kalman_filter abkf_chk u_abkf_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .filtered_angle (out_ch.filtered_angle),
  .corrected_rate (out_ch.corrected_rate),
  .bias_estimate  (out_ch.bias_estimate)
);

// ===== test/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking regression of the angle and gyro bias Kalman filter. A short
// stimulus table covers the extreme fields, the special cases and every
// register, after which six random phases run sensor-like sample streams
// under changing register settings and idle patterns. Every result is
// compared field by field with a typed-in result or a fixed-point predictor.
// ----------------------------------------------------------------------------
module testbench;
  import abkf_pkg::*;

  // Width of the stored angle and bias; the predictor saturates to the same.
  localparam int DW = 32;

  // Cycles without any transfer before the run is declared hung. The slowest
  // legal gap is one sample latency plus the longest receiver stall plus the
  // longest sender gap.
  localparam int STUCK_LIMIT = 4000;

  // Quiet cycles after the last result, covering one full sample latency.
  localparam int SETTLE_CYCLES = 150;

  // Mismatch lines printed before further reports are suppressed.
  localparam int REPORT_CAP = 200;

  localparam int ITEMS_PER_PHASE = 255;
  localparam int RANDOM_PHASES   = 6;

  // A register index that decodes to nothing; writes to it must be dropped.
  localparam logic [2:0] REG_UNUSED = 3'd5;

  localparam longint Q_ONE    = 64'sd1 <<< QF;
  localparam longint HALF_LSB = 64'sd1 <<< (QF - 1);

  // Sensor-like traffic limits, Q16.16: 90 degrees and 200 degrees per second.
  localparam int ANGLE_LIM = 5898240;
  localparam int RATE_LIM  = 13107200;

  typedef struct packed {
    logic signed [31:0] filtered_angle;
    logic signed [31:0] corrected_rate;
    logic signed [31:0] bias_estimate;
  } kf_result_t;

  // Travels with each sample: a typed-in result overrides the prediction.
  typedef struct packed {
    logic       typed;
    kf_result_t want;
  } sample_tag_t;

  typedef enum logic {
    ROW_SAMPLE,
    ROW_WRITE
  } row_kind_t;

  // For a register write, a holds the value and b is unused.
  typedef struct packed {
    row_kind_t   kind;
    logic [2:0]  reg_idx;
    logic [31:0] a;
    logic [31:0] b;
    logic        typed;
    kf_result_t  want;
  } stim_row_t;

  localparam kf_result_t  NO_RES = '0;
  localparam sample_tag_t NO_TAG = '0;
  localparam kf_result_t  ZERO_RES = '{32'sd0, 32'sd0, 32'sd0};
  localparam kf_result_t  PASS_MAX = '{32'sd0, MAX32, 32'sd0};
  localparam kf_result_t  PASS_MIN = '{32'sd0, MIN32, 32'sd0};

  localparam int N_ROWS = 34;

  // Directed stimulus. The first rows run from reset with zero inputs, so
  // angle and bias stay at zero. With a zero time step and a zero observation
  // gain, both gains vanish and the gyro rate passes straight through, which
  // lets the extreme rows be typed in. A write to an unused index in between
  // must change nothing. The rest is left to the predictor: default settings
  // with full-scale inputs, a non-positive innovation variance (no
  // measurement noise and a tiny gain), and finally every register at its
  // top value with the gain at both signed extremes.
  stim_row_t directed_rows [N_ROWS] = '{
    '{ROW_SAMPLE, REG_UNUSED,        32'h0000_0000, 32'h0000_0000, 1'b1, ZERO_RES},
    '{ROW_SAMPLE, REG_UNUSED,        32'h0000_0000, 32'h0000_0000, 1'b1, ZERO_RES},
    '{ROW_WRITE,  REG_TIME_STEP,     32'h0000_0000, 32'h0000_0000, 1'b0, NO_RES},
    '{ROW_WRITE,  REG_MEASURE_GAIN,  32'h0000_0000, 32'h0000_0000, 1'b0, NO_RES},
    '{ROW_WRITE,  REG_UNUSED,        32'hffff_ffff, 32'h0000_0000, 1'b0, NO_RES},
    '{ROW_SAMPLE, REG_UNUSED,        MAX32,         MAX32,         1'b1, PASS_MAX},
    '{ROW_SAMPLE, REG_UNUSED,        MIN32,         MIN32,         1'b1, PASS_MIN},
    '{ROW_SAMPLE, REG_UNUSED,        MIN32,         MAX32,         1'b1, PASS_MAX},
    '{ROW_SAMPLE, REG_UNUSED,        32'h5555_5555, 32'haaaa_aaaa, 1'b1,
      '{32'sd0, 32'shaaaa_aaaa, 32'sd0}},
    '{ROW_SAMPLE, REG_UNUSED,        32'hffff_ffff, 32'h0000_0001, 1'b1,
      '{32'sd0, 32'sd1, 32'sd0}},
    '{ROW_WRITE,  REG_TIME_STEP,     {1'b0, TIME_STEP_RST}, 32'h0, 1'b0, NO_RES},
    '{ROW_WRITE,  REG_MEASURE_GAIN,  MEASURE_GAIN_RST, 32'h0000_0000, 1'b0, NO_RES},
    '{ROW_SAMPLE, REG_UNUSED,        32'h0000_0000, 32'h0064_0000, 1'b0, NO_RES},
    '{ROW_SAMPLE, REG_UNUSED,        32'h000a_0000, 32'h0000_0000, 1'b0, NO_RES},
    '{ROW_SAMPLE, REG_UNUSED,        MAX32,         MAX32,         1'b0, NO_RES},
    '{ROW_SAMPLE, REG_UNUSED,        MIN32,         MIN32,         1'b0, NO_RES},
    '{ROW_SAMPLE, REG_UNUSED,        MAX32,         MIN32,         1'b0, NO_RES},
    '{ROW_SAMPLE, REG_UNUSED,        MIN32,         MAX32,         1'b0, NO_RES},
    '{ROW_SAMPLE, REG_UNUSED,        32'h0000_0000, 32'h0000_0000, 1'b0, NO_RES},
    '{ROW_WRITE,  REG_MEASURE_NOISE, 32'h0000_0000, 32'h0000_0000, 1'b0, NO_RES},
    '{ROW_WRITE,  REG_MEASURE_GAIN,  32'h0000_0001, 32'h0000_0000, 1'b0, NO_RES},
    '{ROW_SAMPLE, REG_UNUSED,        32'h0001_0000, 32'h0001_0000, 1'b0, NO_RES},
    '{ROW_SAMPLE, REG_UNUSED,        32'hffff_0000, MIN32,         1'b0, NO_RES},
    '{ROW_WRITE,  REG_TIME_STEP,     32'hffff_ffff, 32'h0000_0000, 1'b0, NO_RES},
    '{ROW_WRITE,  REG_ANGLE_NOISE,   32'hffff_ffff, 32'h0000_0000, 1'b0, NO_RES},
    '{ROW_WRITE,  REG_BIAS_NOISE,    32'h7fff_ffff, 32'h0000_0000, 1'b0, NO_RES},
    '{ROW_WRITE,  REG_MEASURE_NOISE, 32'h7fff_ffff, 32'h0000_0000, 1'b0, NO_RES},
    '{ROW_WRITE,  REG_MEASURE_GAIN,  MIN32,         32'h0000_0000, 1'b0, NO_RES},
    '{ROW_SAMPLE, REG_UNUSED,        MAX32,         MIN32,         1'b0, NO_RES},
    '{ROW_SAMPLE, REG_UNUSED,        MIN32,         MAX32,         1'b0, NO_RES},
    '{ROW_SAMPLE, REG_UNUSED,        32'h0000_0000, 32'h0000_0000, 1'b0, NO_RES},
    '{ROW_WRITE,  REG_MEASURE_GAIN,  MAX32,         32'h0000_0000, 1'b0, NO_RES},
    '{ROW_SAMPLE, REG_UNUSED,        MAX32,         MAX32,         1'b0, NO_RES},
    '{ROW_SAMPLE, REG_UNUSED,        MIN32,         MIN32,         1'b0, NO_RES}
  };

  logic clk = 1'b0;
  logic rst_n;

  logic              cfg_psel;
  logic              cfg_penable;
  logic              cfg_pwrite;
  logic [CFG_AW-1:0] cfg_paddr;
  logic [CFG_DW-1:0] cfg_pwdata;
  logic [CFG_DW-1:0] cfg_prdata;
  logic              cfg_pready;

  abkf_in_if  in_ch ();
  abkf_out_if out_ch ();

  angle_bias_kalman_filter #(
    .DATA_WIDTH(DW)
  ) u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Predictor copy of the registers and of the filter state. The state is
  // held wider than 32 bits so that every saturation point is explicit.
  cfg_t   filt_cfg;
  longint kf_angle;
  longint kf_bias;
  longint kf_cov [4];

  // Tags of samples handed to the sender, and results still owed by the block.
  sample_tag_t sample_tags[$];
  kf_result_t  owed_results[$];

  int error_count  = 0;
  int stuck_cycles = 0;

  // Idle shaping, changed from phase to phase by the stimulus process.
  int max_gap    = 0;
  int max_stall  = 0;
  int burst_left = 0;

  // Sensor-like traffic: a slowly wandering true angle and rate.
  int true_angle  = 0;
  int true_rate   = 0;
  int gyro_offset = 0;

  function automatic longint clamp32(input longint v);
    if (v > longint'(MAX32)) return longint'(MAX32);
    if (v < longint'(MIN32)) return longint'(MIN32);
    return v;
  endfunction

  function automatic longint clamp_dw(input longint v);
    longint hi;
    longint lo;
    hi = (64'sd1 <<< (DW - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  // Q4.28 product scaling: round to nearest, ties toward plus infinity.
  function automatic longint q28_round(input longint v);
    return (v + HALF_LSB) >>> QF;
  endfunction

  // One filter iteration on the predictor state; returns the result fields.
  function automatic kf_result_t kalman_step(input logic signed [31:0] accel_in,
                                             input logic signed [31:0] gyro_in);
    longint accel, gyro, dt, c, an, bn, rn;
    longint p00, p01, p10, p11;
    longint rate_diff, angle_pred, dp0, dp1, innov;
    longint pct0, pct1, innov_var, k0, k1, t1;
    kf_result_t res;
    accel = accel_in;
    gyro  = gyro_in;
    dt    = filt_cfg.time_step;
    an    = filt_cfg.angle_noise;
    bn    = filt_cfg.bias_noise;
    rn    = filt_cfg.measure_noise;
    c     = $signed(filt_cfg.measure_gain);
    p00   = kf_cov[0];
    p01   = kf_cov[1];
    p10   = kf_cov[2];
    p11   = kf_cov[3];

    // Prediction from the bias-corrected rate.
    rate_diff  = clamp32(gyro - kf_bias);
    angle_pred = clamp_dw(kf_angle + q28_round(rate_diff * dt));

    // First-order covariance propagation with the process noises.
    dp0 = clamp32(an - p01 - p10);
    dp1 = clamp32(-p11);
    p00 = clamp32(p00 + q28_round(dp0 * dt));
    p01 = clamp32(p01 + q28_round(dp1 * dt));
    p10 = clamp32(p10 + q28_round(dp1 * dt));
    p11 = clamp32(p11 + q28_round(bn * dt));

    // Innovation and gains; a non-positive variance leaves both gains at zero.
    innov     = clamp32(accel - angle_pred);
    pct0      = clamp32(q28_round(c * p00));
    pct1      = clamp32(q28_round(c * p10));
    innov_var = rn + q28_round(c * pct0);
    k0 = 0;
    k1 = 0;
    if (innov_var > 0) begin
      k0 = clamp32(pct0 * Q_ONE / innov_var);
      k1 = clamp32(pct1 * Q_ONE / innov_var);
    end

    // Correction of the covariance, the angle and the bias.
    t1 = clamp32(q28_round(c * p01));
    kf_cov[0] = clamp32(p00 - q28_round(k0 * pct0));
    kf_cov[1] = clamp32(p01 - q28_round(k0 * t1));
    kf_cov[2] = clamp32(p10 - q28_round(k1 * pct0));
    kf_cov[3] = clamp32(p11 - q28_round(k1 * t1));
    kf_angle  = clamp_dw(angle_pred + q28_round(k0 * innov));
    kf_bias   = clamp_dw(kf_bias + q28_round(k1 * innov));

    res.filtered_angle = 32'(clamp32(kf_angle));
    res.corrected_rate = 32'(clamp32(gyro - kf_bias));
    res.bias_estimate  = 32'(clamp32(kf_bias));
    return res;
  endfunction

  // Value a register read must return, as the predictor holds it.
  function automatic logic [31:0] register_value(input logic [2:0] idx);
    case (idx)
      REG_TIME_STEP:     return {1'b0, filt_cfg.time_step};
      REG_ANGLE_NOISE:   return {1'b0, filt_cfg.angle_noise};
      REG_BIAS_NOISE:    return {1'b0, filt_cfg.bias_noise};
      REG_MEASURE_NOISE: return {1'b0, filt_cfg.measure_noise};
      REG_MEASURE_GAIN:  return filt_cfg.measure_gain;
      default:           return '0;
    endcase
  endfunction

  // Register values: mostly the extremes, otherwise a random value.
  function automatic logic [31:0] pick_extreme();
    case ($urandom_range(0, 5))
      0:       return 32'h0000_0000;
      1:       return 32'hffff_ffff;
      2:       return 32'h8000_0000;
      3:       return 32'h7fff_ffff;
      default: return $urandom();
    endcase
  endfunction

  task automatic compare_field(input string field, input logic signed [31:0] want,
                               input logic signed [31:0] got);
    if (want !== got) begin
      error_count++;
      if (error_count <= REPORT_CAP) begin
        $display("%0t: %s mismatch, expected %0d (0x%h), actual %0d (0x%h)",
                 $time, field, want, want, got, got);
      end
    end
  endtask

  // APB write, then a read back of the same register. The write lands at the
  // end of the access phase; an index that decodes to nothing is not read.
  task automatic cfg_write(input logic [2:0] idx, input logic [31:0] value);
    logic [31:0] want;
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (cfg_pready !== 1'b1);
    case (idx)
      REG_TIME_STEP:     filt_cfg.time_step     = value[30:0];
      REG_ANGLE_NOISE:   filt_cfg.angle_noise   = value[30:0];
      REG_BIAS_NOISE:    filt_cfg.bias_noise    = value[30:0];
      REG_MEASURE_NOISE: filt_cfg.measure_noise = value[30:0];
      REG_MEASURE_GAIN:  filt_cfg.measure_gain  = value;
      default: ;
    endcase
    cfg_penable <= 1'b0;
    if (idx <= REG_MEASURE_GAIN) begin
      cfg_pwrite <= 1'b0;
      @(posedge clk);
      cfg_penable <= 1'b1;
      do @(posedge clk); while (cfg_pready !== 1'b1);
      want = register_value(idx);
      if (cfg_prdata !== want) begin
        error_count++;
        $display("%0t: read of register %0d, expected 0x%h, actual 0x%h",
                 $time, idx, want, cfg_prdata);
      end
      cfg_penable <= 1'b0;
    end
    cfg_psel <= 1'b0;
    @(posedge clk);
  endtask

  task automatic program_filter(input logic [31:0] ts, input logic [31:0] an,
                                input logic [31:0] bn, input logic [31:0] mn,
                                input logic [31:0] gain);
    cfg_write(REG_TIME_STEP, ts);
    cfg_write(REG_ANGLE_NOISE, an);
    cfg_write(REG_BIAS_NOISE, bn);
    cfg_write(REG_MEASURE_NOISE, mn);
    cfg_write(REG_MEASURE_GAIN, gain);
  endtask

  // Offers one sample and holds it until its transfer. Samples go out in
  // bursts; valid is only lowered when a gap follows.
  task automatic send_sample(input logic [31:0] accel, input logic [31:0] gyro,
                             input sample_tag_t tag);
    int gap;
    sample_tags.push_back(tag);
    in_ch.valid       <= 1'b1;
    in_ch.accel_angle <= accel;
    in_ch.gyro_rate   <= gyro;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 11);
      gap = $urandom_range(0, max_gap);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Stops offering samples and waits until every owed result has arrived
  // and one more sample latency has passed.
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (owed_results.size() != 0 || sample_tags.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Both channels are observed at the clock edge, before any update of that
  // edge lands, so the order of processes within a time step does not matter.
  always @(posedge clk) begin : channel_monitor
    sample_tag_t tag;
    kf_result_t  predicted;
    kf_result_t  got;
    kf_result_t  want;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        predicted = kalman_step(in_ch.accel_angle, in_ch.gyro_rate);
        tag = sample_tags.pop_front();
        owed_results.push_back(tag.typed ? tag.want : predicted);
      end
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.filtered_angle, out_ch.corrected_rate, out_ch.bias_estimate};
        if (owed_results.size() == 0) begin
          error_count++;
          $display("%0t: result transfer with no sample pending, actual 0x%h",
                   $time, got);
        end else begin
          want = owed_results.pop_front();
          compare_field("filtered_angle", want.filtered_angle, got.filtered_angle);
          compare_field("corrected_rate", want.corrected_rate, got.corrected_rate);
          compare_field("bias_estimate", want.bias_estimate, got.bias_estimate);
        end
      end
    end
  end

  // Result side: random stalls whose length is bounded per phase; a bound
  // of zero keeps ready high throughout.
  initial begin : result_sink
    int stall_left;
    stall_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else if (max_stall > 0 && $urandom_range(0, 3) == 0) begin
        stall_left = $urandom_range(1, max_stall) - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Hang detection: any transfer or register access restarts the count.
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        cfg_psel) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= STUCK_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, STUCK_LIMIT);
      $display("angle_bias_kalman_filter regression: fail");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  initial begin : stimulus
    int          pick;
    logic [31:0] accel;
    logic [31:0] gyro;

    rst_n             <= 1'b0;
    in_ch.valid       <= 1'b0;
    in_ch.accel_angle <= '0;
    in_ch.gyro_rate   <= '0;
    cfg_psel          <= 1'b0;
    cfg_penable       <= 1'b0;
    cfg_pwrite        <= 1'b0;
    cfg_paddr         <= '0;
    cfg_pwdata        <= '0;

    filt_cfg  = '{TIME_STEP_RST, ANGLE_NOISE_RST, BIAS_NOISE_RST, MEASURE_NOISE_RST,
                  MEASURE_GAIN_RST};
    kf_angle  = 0;
    kf_bias   = 0;
    kf_cov    = '{longint'(P_ONE), 0, 0, longint'(P_ONE)};

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed table, with moderate idling on both sides.
    max_gap   = 30;
    max_stall = 20;
    for (int i = 0; i < N_ROWS; i++) begin
      if (directed_rows[i].kind == ROW_WRITE) begin
        wait_idle();
        cfg_write(directed_rows[i].reg_idx, directed_rows[i].a);
      end else begin
        send_sample(directed_rows[i].a, directed_rows[i].b,
                    '{directed_rows[i].typed, directed_rows[i].want});
      end
    end

    // Random phases. Each reprograms every register, then runs mostly
    // sensor-like streams with some small-signal and full-range noise mixed in.
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      wait_idle();
      case (phase)
        0: begin
          // Nominal settings, no idling on either side.
          program_filter({1'b0, TIME_STEP_RST}, {1'b0, ANGLE_NOISE_RST},
                         {1'b0, BIAS_NOISE_RST}, {1'b0, MEASURE_NOISE_RST},
                         MEASURE_GAIN_RST);
          max_gap   = 0;
          max_stall = 0;
        end
        1: begin
          program_filter($urandom_range(0, 1 << 24), $urandom_range(0, 1 << 26),
                         $urandom_range(0, 1 << 26), $urandom_range(0, 1 << 29),
                         int'($urandom_range(0, 1 << 30)) - (1 << 29));
          max_gap   = 40;
          max_stall = 8;
        end
        2: begin
          // No measurement noise and a tiny gain: the innovation variance
          // rounds to zero or below, so no correction ever happens.
          program_filter($urandom_range(0, 1 << 24), $urandom_range(0, 1 << 22),
                         $urandom_range(0, 1 << 22), 32'h0000_0000,
                         int'($urandom_range(0, 6)) - 3);
          max_gap   = 160;
          max_stall = 0;
        end
        3: begin
          program_filter(pick_extreme(), pick_extreme(), pick_extreme(),
                         pick_extreme(), pick_extreme());
          max_gap   = 0;
          max_stall = 300;
        end
        4: begin
          program_filter($urandom(), $urandom(), $urandom(), $urandom(), $urandom());
          max_gap   = 20;
          max_stall = 40;
        end
        default: begin
          program_filter({1'b0, TIME_STEP_RST}, {1'b0, ANGLE_NOISE_RST},
                         {1'b0, BIAS_NOISE_RST}, {1'b0, MEASURE_NOISE_RST},
                         MEASURE_GAIN_RST);
          max_gap   = 160;
          max_stall = 300;
        end
      endcase
      gyro_offset = int'($urandom_range(0, 655360)) - 327680;

      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
          true_rate = true_rate + int'($urandom_range(0, 65536)) - 32768;
          if (true_rate > RATE_LIM) true_rate = RATE_LIM;
          if (true_rate < -RATE_LIM) true_rate = -RATE_LIM;
          true_angle = true_angle + true_rate / 256;
          if (true_angle > ANGLE_LIM) true_angle = ANGLE_LIM;
          if (true_angle < -ANGLE_LIM) true_angle = -ANGLE_LIM;
          accel = true_angle + int'($urandom_range(0, 262144)) - 131072;
          gyro  = true_rate + gyro_offset + int'($urandom_range(0, 8192)) - 4096;
        end else if (pick < 85) begin
          accel = int'($urandom_range(0, 2097152)) - 1048576;
          gyro  = int'($urandom_range(0, 2097152)) - 1048576;
        end else begin
          accel = $urandom();
          gyro  = $urandom();
        end
        send_sample(accel, gyro, NO_TAG);
      end
    end

    wait_idle();
    if (error_count == 0) begin
      $display("angle_bias_kalman_filter regression: pass");
    end else begin
      $display("angle_bias_kalman_filter regression: fail");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/abkf_pkg.sv
design/abkf_if.sv
design/abkf_cfg.sv
design/abkf_mul.sv
design/abkf_div.sv
design/angle_bias_kalman_filter.sv
design/abkf_chk.sv
test/testbench.sv
